// ===== sv/lkc_pkg.sv =====
// Shared types and constants for the LRU-K block cache directory.
`timescale 1ns / 1ps
`default_nettype none

package lkc_pkg;

  // Field widths
  localparam int TAB_W = 31;
  localparam int BLK_W = 31;
  localparam int HND_W = 32;
  localparam int HIT_W = 8;
  localparam int OCC_W = 5;
  localparam int THR_W = 8;
  localparam int CNT_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESH = 1'b1;

  // Register reset values
  localparam logic [OCC_W-1:0] OCC_RESET = 5'd16;
  localparam logic [THR_W-1:0] THR_RESET = 8'd2;

  // Request codes
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam logic [HIT_W-1:0] HITS_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_UPDATE,
    S_UPD_END,
    S_DONE
  } state_t;

  // Saturating increments
  function automatic logic [CNT_W-1:0] sat_inc_cnt(input logic [CNT_W-1:0] v);
    sat_inc_cnt = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [HIT_W-1:0] sat_inc_hits(input logic [HIT_W-1:0] v);
    sat_inc_hits = (v == HITS_MAX) ? v : v + HIT_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== sv/lkc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/lkc_scan.sv =====
// Scan unit: walks the entries one per cycle while step is high, for key match, occupancy, victim and free slot.
`timescale 1ns / 1ps
`default_nettype none

module lkc_scan
  import lkc_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    clear,
  input  wire logic                    step,
  input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] idx,
  input  wire logic                    e_valid,
  input  wire logic [TAB_W-1:0]        e_tab,
  input  wire logic [BLK_W-1:0]        e_blk,
  input  wire logic [HND_W-1:0]        e_handle,
  input  wire logic [HIT_W-1:0]        e_hits,
  input  wire logic                    e_hot,
  input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] e_rank,
  input  wire logic [TAB_W-1:0]        key_tab,
  input  wire logic [BLK_W-1:0]        key_blk,
  output logic                         found,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] found_idx,
  output logic [HND_W-1:0]             f_handle,
  output logic [HIT_W-1:0]             f_hits,
  output logic                         f_hot,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] f_rank,
  output logic [$clog2(CAPACITY+1)-1:0] count,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] victim_idx,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] free_idx
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic          cold_ok;
  logic [IW-1:0] cold_idx;
  logic [IW-1:0] cold_rank;
  logic          hot_ok;
  logic [IW-1:0] hot_idx;
  logic [IW-1:0] hot_rank;
  logic          free_ok;
  logic          match;
  logic          cold_take;
  logic          hot_take;

  // Compare stage for the current entry
  assign match     = e_valid && (e_tab == key_tab) && (e_blk == key_blk);
  assign cold_take = e_valid && !e_hot && (!cold_ok || (e_rank > cold_rank));
  assign hot_take  = e_valid && e_hot && (!hot_ok || (e_rank > hot_rank));

  // Control flags
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found   <= 1'b0;
      cold_ok <= 1'b0;
      hot_ok  <= 1'b0;
      free_ok <= 1'b0;
      count   <= '0;
    end else if (step) begin
      if (match) found <= 1'b1;
      if (cold_take) cold_ok <= 1'b1;
      if (hot_take) hot_ok <= 1'b1;
      if (!e_valid) free_ok <= 1'b1;
      if (e_valid) count <= count + CW'(1);
    end
  end

  // Captured indexes and matched entry fields
  always_ff @(posedge clk) begin
    if (step) begin
      if (match && !found) begin
        found_idx <= idx;
        f_handle  <= e_handle;
        f_hits    <= e_hits;
        f_hot     <= e_hot;
        f_rank    <= e_rank;
      end
      if (cold_take) begin
        cold_idx  <= idx;
        cold_rank <= e_rank;
      end
      if (hot_take) begin
        hot_idx  <= idx;
        hot_rank <= e_rank;
      end
      if (!e_valid && !free_ok) free_idx <= idx;
    end
  end

  // Least recent cold entry first, else least recent hot entry
  assign victim_idx = cold_ok ? cold_idx : hot_idx;

endmodule

`default_nettype wire

// ===== sv/lru_k_block_cache_policy.sv =====
// Top level of the two-class LRU-K block cache directory.
// Flow: start to done runs a key scan pass over the entry RAM and then, when the directory
// changes, a rank rewrite pass over the entry RAM before done.
// One request at a time; busy stays high until the done cycle ends, and both passes
// step the single entry RAM read port one entry per cycle.
// Reset: synchronous, active high; clears all valid bits, both counters and
// restores occupancy_limit to 16 and hot_threshold to 2. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module lru_k_block_cache_policy
  import lkc_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 mode,
  input  wire logic [TAB_W-1:0]     table_id,
  input  wire logic [BLK_W-1:0]     block_index,
  input  wire logic [HND_W-1:0]     handle_in,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  output logic                      done,
  output logic                      hit,
  output logic [HND_W-1:0]          handle_out,
  output logic                      evicted,
  output logic [CNT_W-1:0]          hit_total,
  output logic [CNT_W-1:0]          request_total
);

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > OCC_W) ? CW : OCC_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  typedef struct packed {
    logic [TAB_W-1:0] tab;
    logic [BLK_W-1:0] blk;
    logic [HND_W-1:0] handle;
    logic [HIT_W-1:0] hits;
    logic             hot;
    logic [IW-1:0]    rank;
  } entry_t;

  localparam int EW = $bits(entry_t);

  state_t state, state_next;

  logic [OCC_W-1:0]  occ_limit;
  logic [THR_W-1:0]  hot_thresh;
  logic [CAPACITY-1:0] valid;
  logic [IW-1:0]     cnt;
  logic [IW-1:0]     pidx;
  logic              pv_scan;
  logic              pv_upd;

  // Captured request word
  logic              k_mode;
  logic [TAB_W-1:0]  k_tab;
  logic [BLK_W-1:0]  k_blk;
  logic [HND_W-1:0]  k_hin;

  // Entry RAM
  entry_t            rd_entry;
  entry_t            wr_entry;
  logic [EW-1:0]     rd_word;
  logic              ram_we;

  // Scan results
  logic              found;
  logic [IW-1:0]     found_idx;
  logic [HND_W-1:0]  f_handle;
  logic [HIT_W-1:0]  f_hits;
  logic              f_hot;
  logic [IW-1:0]     f_rank;
  logic [CW-1:0]     count;
  logic [IW-1:0]     victim_idx;
  logic [IW-1:0]     free_idx;

  // Decision terms
  logic              accept;
  logic              is_get;
  logic              full;
  logic              do_get;
  logic              do_put;
  logic              promote;
  logic [HIT_W-1:0]  new_hits;
  logic [IW-1:0]     tgt;

  assign busy    = (state != S_IDLE);
  assign done    = (state == S_DONE);
  assign accept  = start && !busy;
  assign rd_entry = entry_t'(rd_word);

  lkc_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pidx),
    .wdata (wr_entry),
    .raddr (cnt),
    .rdata (rd_word)
  );

  lkc_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept),
    .step       (pv_scan),
    .idx        (pidx),
    .e_valid    (valid[pidx]),
    .e_tab      (rd_entry.tab),
    .e_blk      (rd_entry.blk),
    .e_handle   (rd_entry.handle),
    .e_hits     (rd_entry.hits),
    .e_hot      (rd_entry.hot),
    .e_rank     (rd_entry.rank),
    .key_tab    (k_tab),
    .key_blk    (k_blk),
    .found      (found),
    .found_idx  (found_idx),
    .f_handle   (f_handle),
    .f_hits     (f_hits),
    .f_hot      (f_hot),
    .f_rank     (f_rank),
    .count      (count),
    .victim_idx (victim_idx),
    .free_idx   (free_idx)
  );

  // Request decision from the scan results
  always_comb begin
    is_get   = (k_mode == MODE_GET);
    // a limit of zero acts as one, so an empty directory is never full
    full     = (count != '0) &&
               ((CMPW'(count) >= CMPW'(occ_limit)) ||
                (CMPW'(count) == CMPW'(CAPACITY)));
    do_get   = is_get && found;
    do_put   = !is_get && !found;
    new_hits = sat_inc_hits(f_hits);
    promote  = !f_hot && (new_hits >= hot_thresh);
    tgt      = do_get ? found_idx : (full ? victim_idx : free_idx);
  end

  // Rank rewrite for the entry coming out of the RAM
  always_comb begin
    wr_entry = rd_entry;
    if (do_put) begin
      if (pidx == tgt) begin
        wr_entry.tab    = k_tab;
        wr_entry.blk    = k_blk;
        wr_entry.handle = k_hin;
        wr_entry.hits   = HIT_W'(1);
        wr_entry.hot    = 1'b0;
        wr_entry.rank   = '0;
      end else if (!rd_entry.hot) begin
        wr_entry.rank = rd_entry.rank + IW'(1);
      end
    end else begin
      if (pidx == tgt) begin
        wr_entry.hits = new_hits;
        wr_entry.hot  = rd_entry.hot | promote;
        wr_entry.rank = '0;
      end else if (promote) begin
        if (rd_entry.hot) begin
          wr_entry.rank = rd_entry.rank + IW'(1);
        end else if (rd_entry.rank > f_rank) begin
          wr_entry.rank = rd_entry.rank - IW'(1);
        end
      end else if ((rd_entry.hot == f_hot) && (rd_entry.rank < f_rank)) begin
        wr_entry.rank = rd_entry.rank + IW'(1);
      end
    end
    ram_we = pv_upd && ((pidx == tgt) || valid[pidx]);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (start) state_next = S_SCAN;
      S_SCAN:     if (cnt == LAST_IDX) state_next = S_SCAN_END;
      S_SCAN_END: state_next = S_DECIDE;
      S_DECIDE:   state_next = (do_get || do_put) ? S_UPDATE : S_DONE;
      S_UPDATE:   if (cnt == LAST_IDX) state_next = S_UPD_END;
      S_UPD_END:  state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Entry counter and read pipeline tags
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      pv_scan <= 1'b0;
      pv_upd  <= 1'b0;
    end else begin
      pv_scan <= (state == S_SCAN);
      pv_upd  <= (state == S_UPDATE);
      if (accept || (state == S_DECIDE)) begin
        cnt <= '0;
      end else if (((state == S_SCAN) || (state == S_UPDATE)) && (cnt != LAST_IDX)) begin
        cnt <= cnt + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx <= cnt;
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      k_mode <= mode;
      k_tab  <= table_id;
      k_blk  <= block_index;
      k_hin  <= handle_in;
    end
  end

  // Config registers, valid bits and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      occ_limit     <= OCC_RESET;
      hot_thresh    <= THR_RESET;
      valid         <= '0;
      hit_total     <= '0;
      request_total <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OCC_LIMIT:  occ_limit  <= cfg_data[OCC_W-1:0];
          CFG_HOT_THRESH: hot_thresh <= cfg_data[THR_W-1:0];
          default:        ;
        endcase
      end
      if (state == S_DECIDE) begin
        if (do_put) valid[tgt] <= 1'b1;
        if (is_get) request_total <= sat_inc_cnt(request_total);
        if (do_get) hit_total <= sat_inc_cnt(hit_total);
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      hit        <= found;
      handle_out <= do_get ? f_handle : '0;
      evicted    <= do_put && full;
    end
  end

endmodule

`default_nettype wire
